FILE: hdl/msd_pkg.sv
// ----------------------------------------------------------------------------
// msd_pkg - shared definitions for the media stream deframer
// Header layout constants, phase encoding and the result beat type.
// ----------------------------------------------------------------------------
package msd_pkg;

  // Header layout
  localparam logic [7:0] MAGIC_BYTE  = 8'hAA;
  localparam int         HDR_BYTES   = 16;
  localparam int         HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  // Fixed byte positions inside a header
  localparam int PTYPE_POS  = 5;
  localparam int LEN_POS0   = 10;  // most significant length byte
  localparam int LEN_POS1   = 11;
  localparam int LEN_POS2   = 12;
  localparam int LEN_POS3   = 13;  // least significant length byte
  localparam int MTYPE_POS  = 14;

  // Header field codes
  localparam logic [7:0] PTYPE_MEDIA = 8'd1;
  localparam logic [7:0] MTYPE_AUDIO = 8'd0;
  localparam logic [7:0] MTYPE_MAX   = 8'd2;

  // Default width of the payload length counter
  localparam int LENGTH_BITS_DEF = 31;

  // Deframer phase
  typedef enum logic [1:0] {
    PH_SCAN    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_FIRST   = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_e;

  // One outgoing transaction
  typedef struct packed {
    logic [7:0] data;
    logic       to_audio;
    logic       packet_start;
    logic       last_of_run;
  } msd_beat_t;

endpackage

FILE: hdl/media_stream_deframer.sv
// ----------------------------------------------------------------------------
// media_stream_deframer - strips 16-byte media headers from a byte stream
// Routes payload to audio or video, passes other bytes through and replays
// headers that are not media headers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  : in_valid_i / in_stall_o, one stream byte per transaction.
//   Output channel : out_valid_o / out_stall_i, one routed byte per transaction
//                    with to_audio_o, packet_start_o and last_of_run_o.
//   A byte that produces a result is registered in the output register, or in
//   the skid entry if the receiver stalls. Header bytes produce nothing until
//   the header ends. Throughput: one byte per cycle while neither a replay nor
//   a full skid entry stalls the input, set by the single decode stage between
//   the input handshake and the output register. A rejected header is replayed
//   from the 16-entry header store, one byte per cycle while the skid entry is
//   free, through its single read port; the input stalls until the replay ends.
//   A receiver stall fills the one-entry skid stage first; the input stalls
//   only once the skid entry is occupied, so one more byte is always taken.
//   Reset: scanning for magic, route video, no transactions pending.
//   The header store has no reset; it is fully written before it is read.
// ----------------------------------------------------------------------------
module media_stream_deframer #(
  parameter int LENGTH_BITS = msd_pkg::LENGTH_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  // output stream
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       to_audio_o,
  output logic       packet_start_o,
  output logic       last_of_run_o
);

  localparam logic [LENGTH_BITS-1:0] LenOne = LENGTH_BITS'(1);
  localparam logic [LENGTH_BITS-1:0] LenCap = {LENGTH_BITS{1'b1}};

  // Control state
  msd_pkg::phase_e                   phase_q, phase_d;
  logic [msd_pkg::HDR_IDX_W-1:0]     hcnt_q, hcnt_d;
  logic [msd_pkg::HDR_IDX_W-1:0]     rcnt_q, rcnt_d;
  logic [LENGTH_BITS-1:0]            rem_q, rem_d;
  logic                              audio_q, audio_d;
  logic                              replay_q, replay_d;

  // Header store
  logic [7:0]                        hdr_q [msd_pkg::HDR_BYTES];
  logic                              hdr_we;
  logic [msd_pkg::HDR_IDX_W-1:0]     hdr_wa;

  // Output register and skid entry
  msd_pkg::msd_beat_t                out_q, skid_q, src;
  logic                              out_valid_q, skid_valid_q;
  logic                              src_valid;
  logic                              out_ready;
  logic                              in_accept;

  // Header decode
  logic [31:0]                       hdr_len;
  logic [LENGTH_BITS-1:0]            len_sat;
  logic                              hdr_media;

  assign in_stall_o = replay_q | skid_valid_q;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign out_ready  = ~out_valid_q | ~out_stall_i;

  assign hdr_len = {hdr_q[msd_pkg::LEN_POS0], hdr_q[msd_pkg::LEN_POS1],
                    hdr_q[msd_pkg::LEN_POS2], hdr_q[msd_pkg::LEN_POS3]};
  // saturate oversized lengths to the counter range
  assign len_sat = (|hdr_len[31:LENGTH_BITS]) ? LenCap : hdr_len[LENGTH_BITS-1:0];
  assign hdr_media = (hdr_q[msd_pkg::PTYPE_POS] == msd_pkg::PTYPE_MEDIA) &&
                     (hdr_q[msd_pkg::MTYPE_POS] <= msd_pkg::MTYPE_MAX);

  // Decode: next state and the transaction to produce this cycle
  always_comb begin
    phase_d          = phase_q;
    hcnt_d           = hcnt_q;
    rcnt_d           = rcnt_q;
    rem_d            = rem_q;
    audio_d          = audio_q;
    replay_d         = replay_q;
    hdr_we           = 1'b0;
    hdr_wa           = hcnt_q;
    src_valid        = 1'b0;
    src.data         = in_byte_i;
    src.to_audio     = audio_q;
    src.packet_start = 1'b0;
    src.last_of_run  = 1'b1;

    if (replay_q) begin
      // replay a rejected header, one byte per free slot
      if (!skid_valid_q) begin
        src_valid       = 1'b1;
        src.data        = hdr_q[rcnt_q];
        src.last_of_run = (rcnt_q == msd_pkg::HDR_LAST);
        rcnt_d          = rcnt_q + 1'b1;
        if (rcnt_q == msd_pkg::HDR_LAST) begin
          replay_d = 1'b0;
        end
      end
    end else if (in_accept) begin
      case (phase_q)
        msd_pkg::PH_HEADER: begin
          hdr_we = 1'b1;
          if (hcnt_q == msd_pkg::HDR_LAST) begin
            hcnt_d = '0;
            if (hdr_media) begin
              audio_d = (hdr_q[msd_pkg::MTYPE_POS] == msd_pkg::MTYPE_AUDIO);
              rem_d   = len_sat;
              phase_d = (len_sat != '0) ? msd_pkg::PH_FIRST : msd_pkg::PH_SCAN;
            end else begin
              replay_d = 1'b1;
              rcnt_d   = '0;
              phase_d  = msd_pkg::PH_SCAN;
            end
          end else begin
            hcnt_d = hcnt_q + 1'b1;
          end
        end
        msd_pkg::PH_FIRST, msd_pkg::PH_PAYLOAD: begin
          src_valid        = 1'b1;
          src.packet_start = (phase_q == msd_pkg::PH_FIRST);
          if (rem_q != '0) begin
            rem_d = rem_q - LenOne;
          end
          phase_d = (rem_q <= LenOne) ? msd_pkg::PH_SCAN : msd_pkg::PH_PAYLOAD;
        end
        default: begin
          if (in_byte_i == msd_pkg::MAGIC_BYTE) begin
            hdr_we  = 1'b1;
            hdr_wa  = '0;
            hcnt_d  = msd_pkg::HDR_IDX_W'(1);
            phase_d = msd_pkg::PH_HEADER;
          end else begin
            src_valid = 1'b1;
          end
        end
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= msd_pkg::PH_SCAN;
      hcnt_q   <= '0;
      rcnt_q   <= '0;
      rem_q    <= '0;
      audio_q  <= 1'b0;
      replay_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hcnt_q   <= hcnt_d;
      rcnt_q   <= rcnt_d;
      rem_q    <= rem_d;
      audio_q  <= audio_d;
      replay_q <= replay_d;
    end
  end

  // Header store write
  always_ff @(posedge clk_i) begin
    if (hdr_we) begin
      hdr_q[hdr_wa] <= in_byte_i;
    end
  end

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (src_valid) begin
      if (out_ready) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready) begin
        out_q <= skid_q;
      end
    end else if (src_valid) begin
      if (out_ready) begin
        out_q <= src;
      end else begin
        skid_q <= src;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_q.data;
  assign to_audio_o     = out_q.to_audio;
  assign packet_start_o = out_q.packet_start;
  assign last_of_run_o  = out_q.last_of_run;

endmodule

FILE: hdl/msd_checker.sv
// ----------------------------------------------------------------------------
// msd_checker - port-level checks for the media stream deframer
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module msd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       to_audio_o,
  input logic       packet_start_o,
  input logic       last_of_run_o
);

  // Stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_byte_i))
    else $error("stalled input transaction changed");

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(to_audio_o) && $stable(packet_start_o) && $stable(last_of_run_o))
    else $error("stalled output transaction changed");

  // A packet start is a payload byte, which always ends its run
  a_start_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_start_o |-> last_of_run_o)
    else $error("packet start without last_of_run");

  // A run that is not finished keeps the input stalled (header replay)
  a_replay_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |-> in_stall_o)
    else $error("input open during header replay");

  // Stall only starts after an accepted input transaction
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall without a preceding transaction");

endmodule

bind media_stream_deframer msd_checker u_msd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .in_byte_i      (in_byte_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .out_byte_o     (out_byte_o),
  .to_audio_o     (to_audio_o),
  .packet_start_o (packet_start_o),
  .last_of_run_o  (last_of_run_o)
);
